// ===== design/mpd_pkg.sv =====
// ---------------------------------------------------------------------------
// mpd_pkg: shared types and constants of the MQTT packet deframer
// Packet type, phase, byte role and status codes, and the varint length limit.
// ---------------------------------------------------------------------------
package mpd_pkg;

  // Varint remaining-length field: at most this many bytes (range 1..4)
  localparam int unsigned LenBytesMax = 4;

  localparam logic [3:0] TypeConnack = 4'd2;
  localparam logic [3:0] TypePublish = 4'd3;

  typedef enum logic [2:0] {
    PH_TYPE    = 3'd0,
    PH_LEN     = 3'd1,
    PH_TLEN    = 3'd2,
    PH_TOPIC   = 3'd3,
    PH_PAYLOAD = 3'd4,
    PH_CONNACK = 3'd5,
    PH_BODY    = 3'd6
  } phase_t;

  typedef enum logic [2:0] {
    ROLE_TYPE    = 3'd0,
    ROLE_LEN     = 3'd1,
    ROLE_TLEN    = 3'd2,
    ROLE_TOPIC   = 3'd3,
    ROLE_PAYLOAD = 3'd4,
    ROLE_CONNACK = 3'd5,
    ROLE_OTHER   = 3'd6
  } role_t;

  typedef enum logic [2:0] {
    ST_BUSY            = 3'd0,
    ST_OK              = 3'd1,
    ST_SHORT           = 3'd2,
    ST_LEN_INCOMPLETE  = 3'd3,
    ST_LEN_LONG        = 3'd4,
    ST_TOPIC_TRUNC     = 3'd5,
    ST_CONNACK_SHORT   = 3'd6,
    ST_CONNACK_REFUSED = 3'd7
  } status_t;

endpackage

// ===== design/mqtt_packet_deframer.sv =====
// ---------------------------------------------------------------------------
// mqtt_packet_deframer: MQTT 3.1.1 fixed-header deframer
// Parses a received packet buffer one byte per item and tags every byte.
// ---------------------------------------------------------------------------
// One input byte gives one result item in the next cycle, from a single
// output register. A new byte is accepted every cycle while the output
// register is empty or being drained; the per-byte parse state updates in
// the same cycle, so the rate is one byte per clock. The first byte gives
// the packet type, the next ones a base-128 remaining length of at most
// four bytes; PUBLISH topic and payload bytes and CONNACK fields are tagged.
// The byte flagged tlast closes the packet with a final status and the
// following byte starts a new packet. The remaining length is reported but
// never compared with the buffer size.
module mqtt_packet_deframer #(
  parameter int unsigned LenBytesMax = mpd_pkg::LenBytesMax
) (
  input  logic        clk,
  input  logic        rst_n,
  input  logic        in_tvalid,
  output logic        in_tready,
  input  logic [7:0]  in_tdata,   // [7:0] data_byte
  input  logic        in_tlast,   // last_byte
  output logic        out_tvalid,
  input  logic        out_tready,
  // [3:0] packet_type, [6:4] byte_role, [34:7] remaining_length,
  // [50:35] topic_length, [58:51] return_code, [61:59] status, [63:62] zero
  output logic [63:0] out_tdata,
  output logic        out_tlast   // packet_end
);

  mpd_pkg::phase_t  phase_r, phase_nxt;
  logic [3:0]       type_r, type_nxt;
  logic [27:0]      accum_r, accum_nxt;
  logic [2:0]       len_cnt_r, len_cnt_nxt;
  logic [15:0]      tlen_r, tlen_nxt;
  logic [15:0]      left_r, left_nxt;
  logic [1:0]       body_cnt_r, body_cnt_nxt;
  logic [7:0]       code_r, code_nxt;
  mpd_pkg::status_t err_r, err_nxt;
  logic             tlen_vld_r, tlen_vld_nxt;

  mpd_pkg::role_t   role;
  mpd_pkg::status_t status;
  logic [27:0]      len_add;
  logic             more;
  logic             accept;

  logic             out_vld_r;
  logic [63:0]      out_data_r;
  logic             out_last_r;

  assign in_tready = !out_vld_r || out_tready;
  assign accept    = in_tvalid && in_tready;
  assign more      = in_tdata[7];

  // 7-bit group placed by its position in the varint
  always_comb begin
    case (len_cnt_r[1:0])
      2'd0:    len_add = {21'd0, in_tdata[6:0]};
      2'd1:    len_add = {14'd0, in_tdata[6:0], 7'd0};
      2'd2:    len_add = {7'd0, in_tdata[6:0], 14'd0};
      default: len_add = {in_tdata[6:0], 21'd0};
    endcase
  end

  always_comb begin
    phase_nxt    = phase_r;
    type_nxt     = type_r;
    accum_nxt    = accum_r;
    len_cnt_nxt  = len_cnt_r;
    tlen_nxt     = tlen_r;
    left_nxt     = left_r;
    body_cnt_nxt = body_cnt_r;
    code_nxt     = code_r;
    err_nxt      = err_r;
    tlen_vld_nxt = tlen_vld_r;
    role         = mpd_pkg::ROLE_OTHER;
    status       = mpd_pkg::ST_BUSY;

    case (phase_r)
      mpd_pkg::PH_TYPE: begin
        type_nxt     = in_tdata[7:4];
        accum_nxt    = '0;
        len_cnt_nxt  = '0;
        tlen_nxt     = '0;
        left_nxt     = '0;
        body_cnt_nxt = '0;
        code_nxt     = '0;
        err_nxt      = mpd_pkg::ST_BUSY;
        tlen_vld_nxt = 1'b0;
        role         = mpd_pkg::ROLE_TYPE;
        if (in_tlast) status = mpd_pkg::ST_SHORT;
        else phase_nxt = mpd_pkg::PH_LEN;
      end
      mpd_pkg::PH_LEN: begin
        role        = mpd_pkg::ROLE_LEN;
        accum_nxt   = accum_r + len_add;
        len_cnt_nxt = len_cnt_r + 3'd1;
        if (more && (len_cnt_nxt >= 3'(LenBytesMax))) begin
          err_nxt = mpd_pkg::ST_LEN_LONG;
          if (in_tlast) status = mpd_pkg::ST_LEN_LONG;
          else phase_nxt = mpd_pkg::PH_BODY;
        end else if (more) begin
          if (in_tlast) status = mpd_pkg::ST_LEN_INCOMPLETE;
        end else if (type_r == mpd_pkg::TypePublish) begin
          if (in_tlast) status = mpd_pkg::ST_TOPIC_TRUNC;
          else begin
            phase_nxt    = mpd_pkg::PH_TLEN;
            body_cnt_nxt = '0;
          end
        end else if (type_r == mpd_pkg::TypeConnack) begin
          if (in_tlast) status = mpd_pkg::ST_CONNACK_SHORT;
          else begin
            phase_nxt    = mpd_pkg::PH_CONNACK;
            body_cnt_nxt = '0;
          end
        end else begin
          if (in_tlast) status = mpd_pkg::ST_OK;
          else phase_nxt = mpd_pkg::PH_BODY;
        end
      end
      mpd_pkg::PH_TLEN: begin
        role = mpd_pkg::ROLE_TLEN;
        if (body_cnt_r == 2'd0) begin
          tlen_nxt     = {in_tdata, 8'd0};
          body_cnt_nxt = 2'd1;
          if (in_tlast) status = mpd_pkg::ST_TOPIC_TRUNC;
        end else begin
          tlen_nxt     = tlen_r | {8'd0, in_tdata};
          left_nxt     = tlen_nxt;
          tlen_vld_nxt = 1'b1;
          body_cnt_nxt = 2'd2;
          if (in_tlast)
            status = (tlen_nxt == 16'd0) ? mpd_pkg::ST_OK : mpd_pkg::ST_TOPIC_TRUNC;
          else
            phase_nxt = (tlen_nxt == 16'd0) ? mpd_pkg::PH_PAYLOAD : mpd_pkg::PH_TOPIC;
        end
      end
      mpd_pkg::PH_TOPIC: begin
        role = mpd_pkg::ROLE_TOPIC;
        if (left_r != 16'd0) left_nxt = left_r - 16'd1;
        if (in_tlast)
          status = (left_nxt == 16'd0) ? mpd_pkg::ST_OK : mpd_pkg::ST_TOPIC_TRUNC;
        else if (left_nxt == 16'd0)
          phase_nxt = mpd_pkg::PH_PAYLOAD;
      end
      mpd_pkg::PH_PAYLOAD: begin
        role = mpd_pkg::ROLE_PAYLOAD;
        if (in_tlast) status = mpd_pkg::ST_OK;
      end
      mpd_pkg::PH_CONNACK: begin
        role = mpd_pkg::ROLE_CONNACK;
        if (body_cnt_r == 2'd0) begin
          // flags byte is read but not judged
          body_cnt_nxt = 2'd1;
          if (in_tlast) status = mpd_pkg::ST_CONNACK_SHORT;
        end else begin
          code_nxt     = in_tdata;
          body_cnt_nxt = 2'd2;
          if (in_tdata != 8'd0) err_nxt = mpd_pkg::ST_CONNACK_REFUSED;
          if (in_tlast)
            status = (in_tdata != 8'd0) ? mpd_pkg::ST_CONNACK_REFUSED : mpd_pkg::ST_OK;
          else
            phase_nxt = mpd_pkg::PH_BODY;
        end
      end
      default: begin
        role = mpd_pkg::ROLE_OTHER;
        if (in_tlast)
          status = (err_r != mpd_pkg::ST_BUSY) ? err_r : mpd_pkg::ST_OK;
      end
    endcase

    if (in_tlast) phase_nxt = mpd_pkg::PH_TYPE;
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      phase_r    <= mpd_pkg::PH_TYPE;
      type_r     <= '0;
      accum_r    <= '0;
      len_cnt_r  <= '0;
      tlen_r     <= '0;
      left_r     <= '0;
      body_cnt_r <= '0;
      code_r     <= '0;
      err_r      <= mpd_pkg::ST_BUSY;
      tlen_vld_r <= 1'b0;
    end else if (accept) begin
      phase_r    <= phase_nxt;
      type_r     <= type_nxt;
      accum_r    <= accum_nxt;
      len_cnt_r  <= len_cnt_nxt;
      tlen_r     <= tlen_nxt;
      left_r     <= left_nxt;
      body_cnt_r <= body_cnt_nxt;
      code_r     <= code_nxt;
      err_r      <= err_nxt;
      tlen_vld_r <= tlen_vld_nxt;
    end
  end

  // Result register
  always_ff @(posedge clk) begin
    if (!rst_n) begin
      out_vld_r <= 1'b0;
    end else if (accept) begin
      out_vld_r <= 1'b1;
    end else if (out_tready) begin
      out_vld_r <= 1'b0;
    end
  end

  always_ff @(posedge clk) begin
    if (accept) begin
      out_data_r <= {2'b00, status, code_nxt,
                     (tlen_vld_nxt ? tlen_nxt : 16'd0),
                     accum_nxt, role, type_nxt};
      out_last_r <= in_tlast;
    end
  end

  assign out_tvalid = out_vld_r;
  assign out_tdata  = out_data_r;
  assign out_tlast  = out_last_r;

endmodule

// ===== design/mpd_checker.sv =====
// ---------------------------------------------------------------------------
// mpd_checker: port-level checks of the MQTT packet deframer
// Watches the result channel and flags illegal codes and stall slips.
// ---------------------------------------------------------------------------
module mpd_checker (
  input logic        clk,
  input logic        rst_n,
  input logic        in_tready,
  input logic        out_tvalid,
  input logic        out_tready,
  input logic [63:0] out_tdata,
  input logic        out_tlast
);

  // stalled result item holds
  a_hold: assert property (@(posedge clk) disable iff (!rst_n)
    out_tvalid && !out_tready |=> out_tvalid && $stable(out_tdata) && $stable(out_tlast))
    else $error("result item changed while stalled");

  // a final status shows exactly on the closing item
  a_status_end: assert property (@(posedge clk) disable iff (!rst_n)
    out_tvalid |-> ((out_tdata[61:59] != mpd_pkg::ST_BUSY) == out_tlast))
    else $error("status does not match packet end");

  // no byte role code past the last one, padding stays zero
  a_role_pad: assert property (@(posedge clk) disable iff (!rst_n)
    out_tvalid |-> (out_tdata[6:4] <= mpd_pkg::ROLE_OTHER) && (out_tdata[63:62] == 2'b00))
    else $error("illegal role code or nonzero padding");

  // after a closing item the next result is a type byte
  a_new_packet: assert property (@(posedge clk) disable iff (!rst_n)
    out_tvalid && out_tready && out_tlast ##1 out_tvalid |->
      (out_tdata[6:4] == mpd_pkg::ROLE_TYPE) && (out_tdata[34:7] == 28'd0))
    else $error("packet after end did not start with a type byte");

  // no input is taken while the result register is full and stalled
  a_ready: assert property (@(posedge clk) disable iff (!rst_n)
    out_tvalid && !out_tready |-> !in_tready)
    else $error("input accepted while result register is full");

endmodule

bind mqtt_packet_deframer mpd_checker u_mpd_checker (
  .clk        (clk),
  .rst_n      (rst_n),
  .in_tready  (in_tready),
  .out_tvalid (out_tvalid),
  .out_tready (out_tready),
  .out_tdata  (out_tdata),
  .out_tlast  (out_tlast)
);
